FILE: hw/rtl/jsd_pkg.sv
package jsd_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX1,
    MODE_BSL2,
    MODE_U2,
    MODE_HEX2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NO_QUOTE     = 4'd0,
    ERR_CONTROL      = 4'd1,
    ERR_CUT_ESCAPE   = 4'd2,
    ERR_BAD_ESCAPE   = 4'd3,
    ERR_BAD_HEX      = 4'd4,
    ERR_NO_LOW       = 4'd5,
    ERR_BAD_LOW      = 4'd6,
    ERR_LONE_LOW     = 4'd7,
    ERR_UNTERMINATED = 4'd8
  } err_e;

  localparam logic [7:0]  ChQuote     = 8'h22;
  localparam logic [7:0]  ChBackslash = 8'h5C;
  localparam logic [7:0]  ChSlash     = 8'h2F;
  localparam logic [7:0]  ChSpace     = 8'h20;
  localparam logic [7:0]  ChLowerU    = 8'h75;
  localparam logic [15:0] HighFirst   = 16'hD800;
  localparam logic [15:0] HighLast    = 16'hDBFF;
  localparam logic [15:0] LowFirst    = 16'hDC00;
  localparam logic [15:0] LowLast     = 16'hDFFF;
  localparam logic [20:0] SuppBase    = 21'h10000;
  localparam logic [20:0] OneByteMax  = 21'h7F;
  localparam logic [20:0] TwoByteMax  = 21'h7FF;
  localparam logic [20:0] ThreeByteMax = 21'hFFFF;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    err_e       error_code;
    logic       last_of_run;
  } out_t;

  // One accepted byte becomes up to four code point bytes and an optional
  // terminal done or error result.
  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  len;
    logic        term;
    kind_e       term_kind;
    err_e        term_err;
  } cmd_t;

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [2:0] utf8_len(logic [20:0] cp);
    logic [2:0] r;
    if (cp <= OneByteMax) begin
      r = 3'd1;
    end else if (cp <= TwoByteMax) begin
      r = 3'd2;
    end else if (cp <= ThreeByteMax) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/jsd_front.sv
module jsd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  jsd_pkg::in_t   in_data_i,
  output logic           cmd_push_o,
  output jsd_pkg::cmd_t  cmd_o
);

  jsd_pkg::mode_e mode_q, mode_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [15:0]    acc_q, acc_d;
  logic [15:0]    hs_q, hs_d;
  jsd_pkg::cmd_t  cmd;

  logic [7:0]  c;
  logic        eot;
  logic [4:0]  hx;
  logic [15:0] acc_new;
  logic [7:0]  esc_val;
  logic        esc_ok;

  assign c       = in_data_i.byte_in;
  assign eot     = in_data_i.end_of_text;
  assign hx      = jsd_pkg::hex_digit(c);
  assign acc_new = {acc_q[11:0], hx[3:0]};

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = c;
    case (c)
      jsd_pkg::ChQuote, jsd_pkg::ChBackslash, jsd_pkg::ChSlash: esc_val = c;
      8'h62: esc_val = 8'h08;
      8'h66: esc_val = 8'h0C;
      8'h6E: esc_val = 8'h0A;
      8'h72: esc_val = 8'h0D;
      8'h74: esc_val = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    hs_d   = hs_q;
    cmd    = '0;
    cmd.term_kind = jsd_pkg::KIND_ERR;
    cmd.term_err  = jsd_pkg::ERR_NO_QUOTE;
    case (mode_q)
      jsd_pkg::MODE_IDLE: begin
        if (c == jsd_pkg::ChQuote) begin
          mode_d = jsd_pkg::MODE_BODY;
          if (eot) begin
            cmd.term     = 1'b1;
            cmd.term_err = jsd_pkg::ERR_UNTERMINATED;
          end
        end else if (c == jsd_pkg::ChSpace || c inside {[8'h09:8'h0D]}) begin
          cmd.term = eot;
        end else begin
          cmd.term = 1'b1;
        end
      end
      jsd_pkg::MODE_BODY: begin
        if (c == jsd_pkg::ChQuote) begin
          cmd.term      = 1'b1;
          cmd.term_kind = jsd_pkg::KIND_DONE;
        end else if (c < jsd_pkg::ChSpace) begin
          cmd.term     = 1'b1;
          cmd.term_err = jsd_pkg::ERR_CONTROL;
        end else if (c == jsd_pkg::ChBackslash) begin
          mode_d = jsd_pkg::MODE_ESC;
          if (eot) begin
            cmd.term     = 1'b1;
            cmd.term_err = jsd_pkg::ERR_CUT_ESCAPE;
          end
        end else begin
          cmd.cp  = {13'd0, c};
          cmd.len = 3'd1;
          if (eot) begin
            cmd.term     = 1'b1;
            cmd.term_err = jsd_pkg::ERR_UNTERMINATED;
          end
        end
      end
      jsd_pkg::MODE_ESC: begin
        if (c == jsd_pkg::ChLowerU) begin
          mode_d = jsd_pkg::MODE_HEX1;
          cnt_d  = 2'd0;
          acc_d  = 16'd0;
          if (eot) begin
            cmd.term     = 1'b1;
            cmd.term_err = jsd_pkg::ERR_BAD_HEX;
          end
        end else if (!esc_ok) begin
          cmd.term     = 1'b1;
          cmd.term_err = jsd_pkg::ERR_BAD_ESCAPE;
        end else begin
          mode_d  = jsd_pkg::MODE_BODY;
          cmd.cp  = {13'd0, esc_val};
          cmd.len = 3'd1;
          if (eot) begin
            cmd.term     = 1'b1;
            cmd.term_err = jsd_pkg::ERR_UNTERMINATED;
          end
        end
      end
      jsd_pkg::MODE_HEX1, jsd_pkg::MODE_HEX2: begin
        if (!hx[4]) begin
          cmd.term     = 1'b1;
          cmd.term_err = jsd_pkg::ERR_BAD_HEX;
        end else if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
          acc_d = acc_new;
          if (eot) begin
            cmd.term     = 1'b1;
            cmd.term_err = (mode_q == jsd_pkg::MODE_HEX1) ?
                           jsd_pkg::ERR_BAD_HEX : jsd_pkg::ERR_NO_LOW;
          end
        end else begin
          cnt_d = 2'd0;
          acc_d = 16'd0;
          if (mode_q == jsd_pkg::MODE_HEX1) begin
            if (acc_new >= jsd_pkg::HighFirst && acc_new <= jsd_pkg::HighLast) begin
              hs_d   = acc_new;
              mode_d = jsd_pkg::MODE_BSL2;
              if (eot) begin
                cmd.term     = 1'b1;
                cmd.term_err = jsd_pkg::ERR_NO_LOW;
              end
            end else if (acc_new >= jsd_pkg::LowFirst && acc_new <= jsd_pkg::LowLast) begin
              cmd.term     = 1'b1;
              cmd.term_err = jsd_pkg::ERR_LONE_LOW;
            end else begin
              mode_d  = jsd_pkg::MODE_BODY;
              cmd.cp  = {5'd0, acc_new};
              cmd.len = jsd_pkg::utf8_len({5'd0, acc_new});
              if (eot) begin
                cmd.term     = 1'b1;
                cmd.term_err = jsd_pkg::ERR_UNTERMINATED;
              end
            end
          end else begin
            if (acc_new < jsd_pkg::LowFirst || acc_new > jsd_pkg::LowLast) begin
              cmd.term     = 1'b1;
              cmd.term_err = jsd_pkg::ERR_BAD_LOW;
            end else begin
              mode_d  = jsd_pkg::MODE_BODY;
              hs_d    = 16'd0;
              cmd.cp  = jsd_pkg::SuppBase + {1'b0, hs_q[9:0], acc_new[9:0]};
              cmd.len = 3'd4;
              if (eot) begin
                cmd.term     = 1'b1;
                cmd.term_err = jsd_pkg::ERR_UNTERMINATED;
              end
            end
          end
        end
      end
      jsd_pkg::MODE_BSL2: begin
        if (c != jsd_pkg::ChBackslash || eot) begin
          cmd.term     = 1'b1;
          cmd.term_err = jsd_pkg::ERR_NO_LOW;
        end else begin
          mode_d = jsd_pkg::MODE_U2;
        end
      end
      jsd_pkg::MODE_U2: begin
        if (c != jsd_pkg::ChLowerU || eot) begin
          cmd.term     = 1'b1;
          cmd.term_err = jsd_pkg::ERR_NO_LOW;
        end else begin
          mode_d = jsd_pkg::MODE_HEX2;
          cnt_d  = 2'd0;
          acc_d  = 16'd0;
        end
      end
      default: begin
        cmd.term = 1'b1;
      end
    endcase
    // Any terminal result sends the decoder back to idle with cleared state.
    if (cmd.term) begin
      mode_d = jsd_pkg::MODE_IDLE;
      cnt_d  = 2'd0;
      acc_d  = 16'd0;
      hs_d   = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsd_pkg::MODE_IDLE;
      cnt_q  <= 2'd0;
      acc_q  <= 16'd0;
      hs_q   <= 16'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      hs_q   <= hs_d;
    end
  end

  assign cmd_push_o = accept_i && (cmd.len != 3'd0 || cmd.term);
  assign cmd_o      = cmd;

  a_term_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push_o && cmd_o.term) |=> (mode_q == jsd_pkg::MODE_IDLE && hs_q == 16'd0))
    else $error("Terminal result did not return the decoder to idle.");

  a_hex_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != jsd_pkg::MODE_HEX1 && mode_q != jsd_pkg::MODE_HEX2)
      |-> (cnt_q == 2'd0 && acc_q == 16'd0))
    else $error("Hex accumulator is not clear outside a hex escape.");

endmodule

FILE: hw/rtl/jsd_fifo.sv
module jsd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jsd_pkg::cmd_t  data_i,
  output logic           full_o,
  input  logic           pop_i,
  output jsd_pkg::cmd_t  data_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsd_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("Command pushed into a full queue.");

endmodule

FILE: hw/rtl/jsd_back.sv
module jsd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jsd_pkg::cmd_t  cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  logic           pop,
  output jsd_pkg::out_t  out_data_o
);

  logic [2:0]    idx_q, idx_d;
  logic          ovalid_q;
  jsd_pkg::out_t out_q;
  jsd_pkg::out_t res;
  logic [2:0]    total;
  logic [2:0]    sel;
  logic          last;
  logic          load;

  assign total = cmd_i.len + {2'd0, cmd_i.term};
  assign last  = (idx_q == total - 3'd1);
  assign sel   = cmd_i.len - 3'd1 - idx_q;
  assign load  = !cmd_empty_i && (!ovalid_q || pop);

  always_comb begin
    res             = '0;
    res.kind        = jsd_pkg::KIND_BYTE;
    res.error_code  = jsd_pkg::ERR_NO_QUOTE;
    res.last_of_run = last;
    if (idx_q == cmd_i.len) begin
      res.kind = cmd_i.term_kind;
      if (cmd_i.term_kind == jsd_pkg::KIND_ERR) begin
        res.error_code = cmd_i.term_err;
      end
    end else if (idx_q == 3'd0) begin
      case (cmd_i.len)
        3'd2:    res.out_byte = {3'b110, cmd_i.cp[10:6]};
        3'd3:    res.out_byte = {4'b1110, cmd_i.cp[15:12]};
        3'd4:    res.out_byte = {5'b11110, cmd_i.cp[20:18]};
        default: res.out_byte = cmd_i.cp[7:0];
      endcase
    end else begin
      case (sel)
        3'd0:    res.out_byte = {2'b10, cmd_i.cp[5:0]};
        3'd1:    res.out_byte = {2'b10, cmd_i.cp[11:6]};
        default: res.out_byte = {2'b10, cmd_i.cp[17:12]};
      endcase
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (pop) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign cmd_pop_o  = load && last;
  assign empty      = !ovalid_q;
  assign out_data_o = out_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_empty_i |-> (idx_q < total))
    else $error("Result index ran past the end of the command.");

  a_idx_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (idx_q == 3'd0))
    else $error("Result index not rewound after a command finished.");

endmodule

FILE: hw/rtl/json_string_literal_decoder.sv
// A byte's first result passes through the command queue and then the output register.
// Throughput: one byte per cycle while the command queue is not full; a byte that yields
// n results holds the output port for each in turn; the command queue absorbs the difference.
// While popped, the output register delivers one result per cycle from the queued commands.
// Reset is asynchronous and active low; it clears the decoder state, the queue and
// the output valid flag, and the block is ready as soon as reset is released.
module json_string_literal_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  jsd_pkg::in_t   in_data_i,
  output logic           empty,
  input  logic           pop,
  output jsd_pkg::out_t  out_data_o
);

  logic          accept;
  logic          cmd_push;
  jsd_pkg::cmd_t cmd_in;
  jsd_pkg::cmd_t cmd_head;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  jsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  jsd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  jsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/jsd_decode_monitor.sv
`timescale 1ns / 1ps

module jsd_decode_monitor (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          full_i,
  input  jsd_pkg::in_t  in_data_i,
  input  logic          empty_i,
  input  logic          pop_i,
  input  jsd_pkg::out_t out_data_i,
  output int unsigned   err_count_o,
  output int unsigned   outstanding_o
);

  jsd_pkg::mode_e mode_q;
  logic [1:0]     digits_q;
  logic [15:0]    accum_q;
  logic [15:0]    high_q;
  jsd_pkg::out_t  expected_q[$];
  jsd_pkg::out_t  oldest;
  int             step_results;
  int unsigned    mismatches = 0;

  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return int'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      return int'(c - "a") + 10;
    end else if (c >= "A" && c <= "F") begin
      return int'(c - "A") + 10;
    end
    return -1;
  endfunction

  function automatic logic [8:0] escape_value(logic [7:0] c);
    case (c)
      jsd_pkg::ChQuote, jsd_pkg::ChBackslash, jsd_pkg::ChSlash: return {1'b1, c};
      "b": return 9'h108;
      "f": return 9'h10C;
      "n": return 9'h10A;
      "r": return 9'h10D;
      "t": return 9'h109;
      default: return 9'h000;
    endcase
  endfunction

  // The error field reads zero, which is the first error code, on other results.
  task automatic add_result(logic [7:0] b, jsd_pkg::kind_e k, jsd_pkg::err_e e);
    jsd_pkg::out_t r;
    r.out_byte = b;
    r.kind = k;
    r.error_code = e;
    r.last_of_run = 1'b0;
    expected_q.insert(expected_q.size(), r);
    step_results++;
  endtask

  task automatic return_idle();
    mode_q = jsd_pkg::MODE_IDLE;
    digits_q = '0;
    accum_q = '0;
    high_q = '0;
  endtask

  task automatic raise_error(jsd_pkg::err_e e);
    return_idle();
    add_result(8'h00, jsd_pkg::KIND_ERR, e);
  endtask

  task automatic resume_body(logic eot);
    mode_q = jsd_pkg::MODE_BODY;
    if (eot) begin
      raise_error(jsd_pkg::ERR_UNTERMINATED);
    end
  endtask

  task automatic add_data(logic [7:0] b);
    add_result(b, jsd_pkg::KIND_BYTE, jsd_pkg::ERR_NO_QUOTE);
  endtask

  task automatic encode_utf8(logic [20:0] cp);
    if (cp <= jsd_pkg::OneByteMax) begin
      add_data(cp[7:0]);
    end else if (cp <= jsd_pkg::TwoByteMax) begin
      add_data({3'b110, cp[10:6]});
      add_data({2'b10, cp[5:0]});
    end else if (cp <= jsd_pkg::ThreeByteMax) begin
      add_data({4'b1110, cp[15:12]});
      add_data({2'b10, cp[11:6]});
      add_data({2'b10, cp[5:0]});
    end else begin
      add_data({5'b11110, cp[20:18]});
      add_data({2'b10, cp[17:12]});
      add_data({2'b10, cp[11:6]});
      add_data({2'b10, cp[5:0]});
    end
  endtask

  task automatic decode_byte(jsd_pkg::in_t item);
    logic [7:0]  c;
    logic        eot;
    int          d;
    logic [8:0]  esc;
    logic [15:0] v;
    c = item.byte_in;
    eot = item.end_of_text;
    step_results = 0;
    case (mode_q)
      jsd_pkg::MODE_IDLE: begin
        if (c == jsd_pkg::ChQuote) begin
          mode_q = jsd_pkg::MODE_BODY;
          if (eot) begin
            raise_error(jsd_pkg::ERR_UNTERMINATED);
          end
        end else if (c == jsd_pkg::ChSpace || (c >= 8'h09 && c <= 8'h0D)) begin
          if (eot) begin
            raise_error(jsd_pkg::ERR_NO_QUOTE);
          end
        end else begin
          raise_error(jsd_pkg::ERR_NO_QUOTE);
        end
      end
      jsd_pkg::MODE_BODY: begin
        if (c == jsd_pkg::ChQuote) begin
          return_idle();
          add_result(8'h00, jsd_pkg::KIND_DONE, jsd_pkg::ERR_NO_QUOTE);
        end else if (c < jsd_pkg::ChSpace) begin
          raise_error(jsd_pkg::ERR_CONTROL);
        end else if (c == jsd_pkg::ChBackslash) begin
          mode_q = jsd_pkg::MODE_ESC;
          if (eot) begin
            raise_error(jsd_pkg::ERR_CUT_ESCAPE);
          end
        end else begin
          add_data(c);
          resume_body(eot);
        end
      end
      jsd_pkg::MODE_ESC: begin
        esc = escape_value(c);
        if (c == jsd_pkg::ChLowerU) begin
          mode_q = jsd_pkg::MODE_HEX1;
          digits_q = '0;
          accum_q = '0;
          if (eot) begin
            raise_error(jsd_pkg::ERR_BAD_HEX);
          end
        end else if (!esc[8]) begin
          raise_error(jsd_pkg::ERR_BAD_ESCAPE);
        end else begin
          add_data(esc[7:0]);
          resume_body(eot);
        end
      end
      jsd_pkg::MODE_HEX1, jsd_pkg::MODE_HEX2: begin
        d = nibble_of(c);
        if (d < 0) begin
          raise_error(jsd_pkg::ERR_BAD_HEX);
        end else begin
          accum_q = {accum_q[11:0], d[3:0]};
          if (digits_q != 2'd3) begin
            digits_q++;
            if (eot) begin
              if (mode_q == jsd_pkg::MODE_HEX1) begin
                raise_error(jsd_pkg::ERR_BAD_HEX);
              end else begin
                raise_error(jsd_pkg::ERR_NO_LOW);
              end
            end
          end else begin
            v = accum_q;
            digits_q = '0;
            accum_q = '0;
            if (mode_q == jsd_pkg::MODE_HEX1) begin
              if (v >= jsd_pkg::HighFirst && v <= jsd_pkg::HighLast) begin
                high_q = v;
                mode_q = jsd_pkg::MODE_BSL2;
                if (eot) begin
                  raise_error(jsd_pkg::ERR_NO_LOW);
                end
              end else if (v >= jsd_pkg::LowFirst && v <= jsd_pkg::LowLast) begin
                raise_error(jsd_pkg::ERR_LONE_LOW);
              end else begin
                encode_utf8({5'd0, v});
                resume_body(eot);
              end
            end else if (v < jsd_pkg::LowFirst || v > jsd_pkg::LowLast) begin
              raise_error(jsd_pkg::ERR_BAD_LOW);
            end else begin
              // The low ten bits of each half form the offset above the base.
              encode_utf8(jsd_pkg::SuppBase + {1'b0, high_q[9:0], v[9:0]});
              high_q = '0;
              resume_body(eot);
            end
          end
        end
      end
      jsd_pkg::MODE_BSL2: begin
        if (c != jsd_pkg::ChBackslash || eot) begin
          raise_error(jsd_pkg::ERR_NO_LOW);
        end else begin
          mode_q = jsd_pkg::MODE_U2;
        end
      end
      jsd_pkg::MODE_U2: begin
        if (c != jsd_pkg::ChLowerU || eot) begin
          raise_error(jsd_pkg::ERR_NO_LOW);
        end else begin
          mode_q = jsd_pkg::MODE_HEX2;
          digits_q = '0;
          accum_q = '0;
        end
      end
      default: begin
        raise_error(jsd_pkg::ERR_NO_QUOTE);
      end
    endcase
    if (step_results > 0) begin
      expected_q[expected_q.size() - 1].last_of_run = 1'b1;
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      return_idle();
      expected_q.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none actual %h", $time, out_data_i);
        end else begin
          oldest = expected_q.pop_front();
          check_field("out_byte", oldest.out_byte, out_data_i.out_byte);
          check_field("kind", oldest.kind, out_data_i.kind);
          check_field("error_code", oldest.error_code, out_data_i.error_code);
          check_field("last_of_run", oldest.last_of_run, out_data_i.last_of_run);
        end
      end
      if (push_i && !full_i) begin
        decode_byte(in_data_i);
      end
    end
    err_count_o <= mismatches;
    outstanding_o <= expected_q.size();
  end

endmodule

FILE: tb/tb_json_string_literal_decoder.sv
`timescale 1ns / 1ps

module tb_json_string_literal_decoder;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned BytesPerPhase = 4;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          push = 1'b0;
  logic          full;
  jsd_pkg::in_t  in_data = '0;
  logic          empty;
  logic          pop = 1'b0;
  jsd_pkg::out_t out_data;
  int unsigned   mismatch_count;
  int unsigned   pending_count;
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   cycle_count = 0;
  int unsigned   bytes_sent = 0;
  logic [7:0]    text_q[$];

  always #6 clk = ~clk;

  json_string_literal_decoder dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .push      (push),
    .full      (full),
    .in_data_i (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data)
  );

  jsd_decode_monitor decode_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .in_data_i    (in_data),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_data_i   (out_data),
    .err_count_o  (mismatch_count),
    .outstanding_o(pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    pop <= ($urandom_range(99) >= stall_pct);
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    push <= 1'b1;
    in_data <= {b, eot};
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  // Sends the buffered text; the byte at eot_at carries end of text and ends it.
  task automatic flush_text(input int eot_at);
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == eot_at);
      if (i == eot_at) begin
        break;
      end
    end
    text_q.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endtask

  task automatic send_string(input string s, input bit eot_last);
    add_str(s);
    flush_text(eot_last ? text_q.size() - 1 : -1);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] d, bit upper);
    if (d < 4'd10) begin
      return 8'h30 + d;
    end
    return (upper ? 8'h41 : 8'h61) + d - 8'd10;
  endfunction

  task automatic add_unicode_escape(input logic [15:0] v);
    add_byte(jsd_pkg::ChBackslash);
    add_byte(jsd_pkg::ChLowerU);
    for (int i = 3; i >= 0; i--) begin
      add_byte(hex_char(v[i*4 +: 4], 1'($urandom_range(1))));
    end
  endtask

  task automatic add_piece();
    string      escapes;
    logic [7:0] c;
    escapes = "\"\\/bfnrt";
    case ($urandom_range(6))
      0, 1: begin
        do c = 8'($urandom_range(8'h7E, 8'h20));
        while (c == jsd_pkg::ChQuote || c == jsd_pkg::ChBackslash);
        add_byte(c);
      end
      2: add_byte(8'($urandom_range(8'hFF, 8'h80)));
      3: begin
        add_byte(jsd_pkg::ChBackslash);
        add_byte(escapes[$urandom_range(7)]);
      end
      4: begin
        case ($urandom_range(4))
          0: add_unicode_escape(16'($urandom_range(16'h007F, 16'h0000)));
          1: add_unicode_escape(16'($urandom_range(16'h07FF, 16'h0080)));
          2: add_unicode_escape(16'($urandom_range(16'hD7FF, 16'h0800)));
          3: add_unicode_escape(16'($urandom_range(16'hFFFF, 16'hE000)));
          default: add_unicode_escape(16'($urandom_range(16'hFFFF)));
        endcase
      end
      default: begin
        add_unicode_escape(16'($urandom_range(jsd_pkg::HighLast, jsd_pkg::HighFirst)));
        add_unicode_escape(16'($urandom_range(jsd_pkg::LowLast, jsd_pkg::LowFirst)));
      end
    endcase
  endtask

  // Mostly well-formed literals; some get a byte overwritten or are cut short.
  task automatic random_literal();
    int roll;
    int cut;
    repeat ($urandom_range(2)) begin
      add_byte($urandom_range(1) ? jsd_pkg::ChSpace : 8'($urandom_range(8'h0D, 8'h09)));
    end
    add_byte(jsd_pkg::ChQuote);
    repeat ($urandom_range(6)) add_piece();
    add_byte(jsd_pkg::ChQuote);
    roll = int'($urandom_range(99));
    if (roll < 15) begin
      text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
    end
    if (roll >= 15 && roll < 30) begin
      cut = int'($urandom_range(text_q.size() - 1));
    end else if (roll >= 92) begin
      cut = text_q.size() - 1;
    end else begin
      cut = -1;
    end
    flush_text(cut);
  endtask

  task automatic run_random(input int unsigned sender_idle, input int unsigned receiver_stall);
    int unsigned start;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    start = bytes_sent;
    while (bytes_sent - start < BytesPerPhase) begin
      if ($urandom_range(3) != 0) begin
        random_literal();
      end else begin
        repeat ($urandom_range(3, 1)) begin
          send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
      end
    end
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    for (int w = 8'h09; w <= 8'h0D; w++) begin
      add_byte(8'(w));
    end
    add_byte(jsd_pkg::ChSpace);
    add_str("\"a\"");
    flush_text(-1);
    send_string("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 0);
    send_string("\"\\u0000\\u0080\\u0800\\uFFFF\"", 0);
    send_string("\"\\udbff\\udfff\"", 0);
    text_q = '{jsd_pkg::ChQuote, jsd_pkg::ChSpace, 8'h7F, 8'h80, 8'hFF, jsd_pkg::ChQuote};
    flush_text(-1);
    send_byte("x", 1'b0);
    send_byte(jsd_pkg::ChSpace, 1'b1);
    send_byte(jsd_pkg::ChQuote, 1'b1);
    send_string("\"ab", 1);
    send_string("\"\"", 1);
    text_q = '{jsd_pkg::ChQuote, 8'h1F};
    flush_text(-1);
    text_q = '{jsd_pkg::ChQuote, 8'h00};
    flush_text(1);
    send_string("\"\\", 1);
    send_string("\"\\x", 0);
    send_string("\"\\u12g", 0);
    send_string("\"\\u", 1);
    send_string("\"\\u12", 1);
    send_string("\"\\uD800x", 0);
    send_string("\"\\uD800\\x", 0);
    send_string("\"\\uD800", 1);
    send_string("\"\\uD800\\", 1);
    send_string("\"\\uD800\\u", 1);
    send_string("\"\\uD800\\u12", 1);
    send_string("\"\\uD800\\u12z", 0);
    send_string("\"\\uD800\\u0041", 0);
    send_string("\"\\uDC00", 0);
    send_string("\"\\n", 1);
    send_string("\"\\u0041", 1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(0, 0);
    wait_for_results();
    run_random(63, 0);
    run_random(0, 63);
    run_random(21, 21);
    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
